[rtl/fsp_pkg.sv]
// Shared types, constants and byte-class decode for the FASTA record parser.
package fsp_pkg;

    localparam int FSP_POS_BITS   = 32;
    localparam int FSP_FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    typedef enum logic [2:0] {
        KIND_HDR_BYTE = 3'd0,
        KIND_HDR_END  = 3'd1,
        KIND_BASE     = 3'd2,
        KIND_REC_END  = 3'd3,
        KIND_BAD      = 3'd4,
        KIND_RANGE    = 3'd5
    } fsp_kind_t;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_HEADER    = 3'd1,
        PH_SEQ_START = 3'd2,
        PH_SEQ       = 3'd3,
        PH_DONE      = 3'd4,
        PH_ERROR     = 3'd5
    } fsp_phase_t;

    typedef enum logic [1:0] {
        CLS_BAD = 2'd0,
        CLS_NT  = 2'd1,
        CLS_WS  = 2'd2,
        CLS_AMB = 2'd3
    } fsp_class_t;

    typedef enum logic [1:0] {
        CFG_ALLOW_AMBIGUOUS = 2'd0,
        CFG_RANGE_FROM      = 2'd1,
        CFG_RANGE_LENGTH    = 2'd2
    } fsp_cfg_index_t;

    typedef struct packed {
        logic        allow_ambiguous;
        logic [31:0] range_from;
        logic [31:0] range_length;
    } fsp_cfg_t;

    typedef struct packed {
        fsp_kind_t   kind;
        logic [7:0]  char_out;
        logic [31:0] base_position;
    } fsp_result_t;

    function automatic logic fsp_is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
               (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

    function automatic fsp_class_t fsp_classify(input logic [7:0] c);
        logic [7:0] u;
        fsp_class_t cls;
        u = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ? (c - CASE_DIFF) : c;
        unique case (u)
            "A", "C", "G", "T", "N", "X":                     cls = CLS_NT;
            "B", "D", "H", "K", "M", "R", "S", "V", "W", "Y": cls = CLS_AMB;
            default:                                          cls = CLS_BAD;
        endcase
        // Tabs, line breaks, spaces and digits are skipped inside a sequence.
        if (fsp_is_space(c) || ((c >= CHAR_ZERO) && (c <= CHAR_NINE))) begin
            cls = CLS_WS;
        end
        return cls;
    endfunction

endpackage

[rtl/fsp_core.sv]
// Parser state and per-byte decode producing up to two results per word.
module fsp_core #(
    parameter int POS_BITS = fsp_pkg::FSP_POS_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           byte_in,
    input  logic                 end_of_input,
    input  fsp_pkg::fsp_cfg_t    cfg,
    output logic [1:0]           push_cnt,
    output fsp_pkg::fsp_result_t res0,
    output fsp_pkg::fsp_result_t res1
);
    import fsp_pkg::*;

    // Compare width: holds the saturated count and from + length - 1 without wrap.
    localparam int CW = (POS_BITS > 33) ? POS_BITS : 33;

    fsp_phase_t          phase_reg, phase_next;
    logic                prev_nl_reg, prev_nl_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;

    logic [CW-1:0]       pos_ext, inc_ext, range_last;
    logic [POS_BITS-1:0] pos_inc;
    logic                range_on, too_short, base_keep, is_space;
    fsp_class_t          cls;
    fsp_result_t         end_res;

    // Outcome of a sequence byte.
    logic                seq_prev, seq_end, seq_v0, seq_v1;
    fsp_result_t         seq_r0, seq_r1;
    fsp_phase_t          seq_phase;
    logic                seq_nl;
    logic [POS_BITS-1:0] seq_pos;

    logic                take_seq, pre_v, tail_v;
    fsp_result_t         pre_r, tail_r;

    assign range_on   = (cfg.range_length != 32'd0);
    assign range_last = CW'(cfg.range_from) + CW'(cfg.range_length) - CW'(1);
    assign pos_ext    = CW'(pos_reg);
    assign pos_inc    = (pos_reg == {POS_BITS{1'b1}}) ? pos_reg : pos_reg + POS_BITS'(1);
    assign inc_ext    = CW'(pos_inc);
    assign too_short  = (cfg.range_from == 32'd0) || (pos_ext < range_last);
    assign base_keep  = !range_on ||
                        ((inc_ext >= CW'(cfg.range_from)) && (inc_ext <= range_last));
    assign cls        = fsp_classify(byte_in);
    assign is_space   = fsp_is_space(byte_in);

    always_comb begin
        end_res.kind          = (range_on && too_short) ? KIND_RANGE : KIND_REC_END;
        end_res.char_out      = 8'd0;
        end_res.base_position = pos_ext[31:0];
    end

    // Sequence byte: a '>' after a newline closes the record.
    always_comb begin
        seq_prev  = (phase_reg == PH_SEQ) ? prev_nl_reg : 1'b1;
        seq_end   = seq_prev && (byte_in == CHAR_GT);
        seq_v0    = 1'b0;
        seq_v1    = 1'b0;
        seq_r0    = end_res;
        seq_r1    = '{kind: KIND_HDR_BYTE, char_out: byte_in, base_position: 32'd0};
        seq_phase = PH_SEQ;
        seq_nl    = (byte_in == CHAR_LF);
        seq_pos   = pos_reg;
        if (seq_end) begin
            seq_v0    = 1'b1;
            seq_v1    = !range_on;
            seq_phase = range_on ? PH_DONE : PH_HEADER;
            seq_nl    = 1'b1;
            seq_pos   = '0;
        end else if ((cls == CLS_NT) || ((cls == CLS_AMB) && cfg.allow_ambiguous)) begin
            seq_v0    = base_keep;
            seq_r0    = '{kind: KIND_BASE, char_out: byte_in,
                          base_position: inc_ext[31:0]};
            seq_pos   = pos_inc;
        end else if (cls != CLS_WS) begin
            seq_v0    = 1'b1;
            seq_r0    = '{kind: KIND_BAD, char_out: byte_in, base_position: 32'd0};
            seq_phase = PH_ERROR;
            seq_nl    = prev_nl_reg;
        end
    end

    // Which part of the decode applies in the current phase.
    always_comb begin
        take_seq = 1'b0;
        pre_v    = 1'b0;
        tail_v   = 1'b0;
        pre_r    = '{kind: KIND_HDR_END, char_out: 8'd0, base_position: 32'd0};
        tail_r   = end_res;
        unique case (phase_reg)
            PH_START: begin
                if (!end_of_input && !is_space) begin
                    pre_v = 1'b1;
                    if (byte_in == CHAR_GT) begin
                        pre_r = '{kind: KIND_HDR_BYTE, char_out: byte_in,
                                  base_position: 32'd0};
                    end else begin
                        take_seq = 1'b1;
                    end
                end
            end
            PH_HEADER: begin
                pre_v = 1'b1;
                if (end_of_input) begin
                    tail_v = 1'b1;
                end else if (byte_in != CHAR_LF) begin
                    pre_r = '{kind: KIND_HDR_BYTE, char_out: byte_in,
                              base_position: 32'd0};
                end
            end
            PH_SEQ_START: begin
                if (end_of_input) begin
                    tail_v = 1'b1;
                end else if (!is_space) begin
                    take_seq = 1'b1;
                end
            end
            PH_SEQ: begin
                if (end_of_input) begin
                    tail_v = 1'b1;
                end else begin
                    take_seq = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        phase_next   = phase_reg;
        prev_nl_next = prev_nl_reg;
        pos_next     = pos_reg;
        if (take_seq) begin
            phase_next   = seq_phase;
            prev_nl_next = seq_nl;
            pos_next     = seq_pos;
        end else if (tail_v || ((phase_reg == PH_START) && end_of_input)) begin
            phase_next = PH_DONE;
            if (tail_v) begin
                prev_nl_next = 1'b1;
                pos_next     = '0;
            end
        end else if (pre_v && (phase_reg == PH_START)) begin
            phase_next = PH_HEADER;
        end else if (pre_v && (phase_reg == PH_HEADER) && (byte_in == CHAR_LF)) begin
            phase_next   = PH_SEQ_START;
            prev_nl_next = 1'b1;
        end
    end

    // Results, packed into the first free slots.
    always_comb begin
        logic       v1, v2;
        logic [1:0] cnt;
        v1 = take_seq ? seq_v0 : tail_v;
        v2 = take_seq ? seq_v1 : 1'b0;
        if (pre_v) begin
            res0 = pre_r;
            res1 = take_seq ? seq_r0 : tail_r;
        end else begin
            res0 = take_seq ? seq_r0 : tail_r;
            res1 = seq_r1;
        end
        cnt      = 2'(pre_v) + 2'(v1) + 2'(v2);
        push_cnt = accept ? cnt : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            prev_nl_reg <= 1'b1;
            pos_reg     <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            prev_nl_reg <= prev_nl_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

[rtl/fsp_out_fifo.sv]
// Result queue that takes up to two results per cycle and delivers one.
module fsp_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           push_cnt,
    input  fsp_pkg::fsp_result_t push0,
    input  fsp_pkg::fsp_result_t push1,
    input  logic                 pop,
    output logic                 room2,
    output logic                 head_valid,
    output fsp_pkg::fsp_result_t head
);
    import fsp_pkg::*;

    localparam int AW = $clog2(FSP_FIFO_DEPTH);
    localparam int CNT_W = AW + 1;

    fsp_result_t      mem_reg [FSP_FIFO_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + AW'(1);
    assign head_valid   = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    // Accept a word only when a two-result word still fits.
    assign room2        = (count_reg <= CNT_W'(FSP_FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/fasta_record_parser.sv]
// Top level of the FASTA record parser: configuration registers, parser and result queue.
//
// The s_ channel carries one word per byte of FASTA text; s_tuser set marks end of
// file, and the byte is then ignored. The m_ channel returns tagged results: m_tuser
// holds the kind (header byte, header end, base, record end, bad character, range
// error), m_tdata the character and the 1-based base position or record length.
// The registers allow_ambiguous, range_from and range_length are written through
// cfg_wr_en, cfg_index and cfg_wdata; the user must do so only while the stream is
// idle, which the block itself does not enforce.
// Every accepted byte is decoded in the cycle it arrives and its results enter a
// four-entry queue; m_ presents the results from the queue registers, in order.
// The parser takes one byte per cycle as long as each byte yields at most one
// result and the receiver keeps up; a byte yielding two results leaves an extra
// result in the queue, which drains through the single-result output port.
// s_tready is high while the queue has room for two results, so a stalled
// receiver holds results in the queue and the input stops once it holds more than two.
// Reset empties the queue, returns the parser to skipping leading whitespace and
// loads allow_ambiguous = 1, range_from = 1, range_length = 0.
module fasta_record_parser #(
    parameter int POS_BITS = fsp_pkg::FSP_POS_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] char_out, [39:8] base_position
    output logic [2:0]  m_tuser,   // [2:0] kind
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import fsp_pkg::*;

    fsp_cfg_t    cfg_reg, cfg_next;
    logic        accept, room2, head_valid;
    logic [1:0]  push_cnt;
    fsp_result_t res0, res1, head;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = room2;
    assign m_tvalid = head_valid;
    assign m_tdata  = {head.base_position, head.char_out};
    assign m_tuser  = head.kind;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (fsp_cfg_index_t'(cfg_index))
                CFG_ALLOW_AMBIGUOUS: cfg_next.allow_ambiguous = cfg_wdata[0];
                CFG_RANGE_FROM:      cfg_next.range_from      = cfg_wdata;
                CFG_RANGE_LENGTH:    cfg_next.range_length    = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.allow_ambiguous <= 1'b1;
            cfg_reg.range_from      <= 32'd1;
            cfg_reg.range_length    <= 32'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fsp_core #(
        .POS_BITS(POS_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .byte_in     (s_tdata),
        .end_of_input(s_tuser),
        .cfg         (cfg_reg),
        .push_cnt    (push_cnt),
        .res0        (res0),
        .res1        (res1)
    );

    fsp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_tvalid && m_tready),
        .room2     (room2),
        .head_valid(head_valid),
        .head      (head)
    );

endmodule

[tb/fasta_record_parser_checker.sv]
// Checker for the FASTA record parser: predicts results from accepted words and compares them.
`timescale 1ns / 100ps

module fasta_record_parser_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [7:0] char_out, [39:8] base_position
    input  logic [2:0]  m_tuser,   // [2:0] kind
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatch_count,
    output int          results_owed
);
    import fsp_pkg::*;

    localparam logic [63:0] COUNT_MAX = (64'd1 << FSP_POS_BITS) - 64'd1;

    fsp_result_t owed_results[$];

    fsp_phase_t  parse_phase;
    logic        after_newline;
    logic [63:0] base_count;
    int          emitted_now;

    logic        allow_amb;
    logic [31:0] keep_from;
    logic [31:0] keep_len;

    function automatic logic is_layout(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
               (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

    function automatic fsp_class_t byte_class(input logic [7:0] c);
        logic [7:0] up;
        up = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ? (c - CASE_DIFF) : c;
        if (is_layout(c) || ((c >= CHAR_ZERO) && (c <= CHAR_NINE))) begin
            return CLS_WS;
        end
        case (up)
            "A", "C", "G", "T", "N", "X": return CLS_NT;
            "B", "D", "H", "K", "M", "R", "S", "V", "W", "Y": return CLS_AMB;
            default: return CLS_BAD;
        endcase
    endfunction

    // One input word never yields more than two results.
    task automatic owe(input fsp_kind_t kind, input logic [7:0] ch, input logic [63:0] pos);
        fsp_result_t r;
        if (emitted_now < 2) begin
            r.kind = kind;
            r.char_out = ch;
            r.base_position = pos[31:0];
            owed_results.push_back(r);
            emitted_now++;
        end
    endtask

    task automatic close_record();
        logic [63:0] last_pos;
        if (keep_len != 0) begin
            last_pos = {32'd0, keep_from} + {32'd0, keep_len} - 64'd1;
            if ((keep_from == 0) || (base_count < last_pos)) begin
                owe(KIND_RANGE, 8'd0, base_count);
            end else begin
                owe(KIND_REC_END, 8'd0, base_count);
            end
            parse_phase = PH_DONE;
        end else begin
            owe(KIND_REC_END, 8'd0, base_count);
            parse_phase = PH_START;
        end
        base_count = 64'd0;
        after_newline = 1'b1;
    endtask

    task automatic take_seq_byte(input logic [7:0] c, input logic nl_before);
        fsp_class_t  cls;
        logic [63:0] last_pos;
        if (nl_before && (c == CHAR_GT)) begin
            close_record();
            // With a range set the parser stops after the first record.
            if (parse_phase == PH_START) begin
                owe(KIND_HDR_BYTE, c, 64'd0);
                parse_phase = PH_HEADER;
            end
            return;
        end
        cls = byte_class(c);
        if ((cls == CLS_NT) || ((cls == CLS_AMB) && allow_amb)) begin
            if (base_count < COUNT_MAX) begin
                base_count++;
            end
            last_pos = {32'd0, keep_from} + {32'd0, keep_len} - 64'd1;
            if ((keep_len == 0) ||
                ((base_count >= {32'd0, keep_from}) && (base_count <= last_pos))) begin
                owe(KIND_BASE, c, base_count);
            end
        end else if (cls != CLS_WS) begin
            owe(KIND_BAD, c, 64'd0);
            parse_phase = PH_ERROR;
            return;
        end
        after_newline = (c == CHAR_LF);
        parse_phase = PH_SEQ;
    endtask

    task automatic parse_word(input logic [7:0] c, input logic eof);
        emitted_now = 0;
        case (parse_phase)
            PH_START: begin
                if (eof) begin
                    parse_phase = PH_DONE;
                end else if (is_layout(c)) begin
                end else if (c == CHAR_GT) begin
                    owe(KIND_HDR_BYTE, c, 64'd0);
                    parse_phase = PH_HEADER;
                end else begin
                    // A record without a header line: its header is empty.
                    owe(KIND_HDR_END, 8'd0, 64'd0);
                    take_seq_byte(c, 1'b1);
                end
            end
            PH_HEADER: begin
                if (eof) begin
                    owe(KIND_HDR_END, 8'd0, 64'd0);
                    close_record();
                    parse_phase = PH_DONE;
                end else if (c == CHAR_LF) begin
                    owe(KIND_HDR_END, 8'd0, 64'd0);
                    after_newline = 1'b1;
                    parse_phase = PH_SEQ_START;
                end else begin
                    owe(KIND_HDR_BYTE, c, 64'd0);
                end
            end
            PH_SEQ_START: begin
                if (eof) begin
                    close_record();
                    parse_phase = PH_DONE;
                end else if (!is_layout(c)) begin
                    take_seq_byte(c, 1'b1);
                end
            end
            PH_SEQ: begin
                if (eof) begin
                    close_record();
                    parse_phase = PH_DONE;
                end else begin
                    take_seq_byte(c, after_newline);
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        fsp_result_t want;
        if (!aresetn) begin
            owed_results.delete();
            parse_phase = PH_START;
            after_newline = 1'b1;
            base_count = 64'd0;
            allow_amb = 1'b1;
            keep_from = 32'd1;
            keep_len = 32'd0;
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result word with nothing owed: kind %0d char %0d position %0d",
                           m_tuser, m_tdata[7:0], m_tdata[39:8]);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[7:0] !== want.char_out) begin
                        $error("char_out: expected %0d, got %0d", want.char_out, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[39:8] !== want.base_position) begin
                        $error("base_position: expected %0d, got %0d",
                               want.base_position, m_tdata[39:8]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_word(s_tdata, s_tuser);
            end
            if (cfg_wr_en) begin
                case (fsp_cfg_index_t'(cfg_index))
                    CFG_ALLOW_AMBIGUOUS: allow_amb = cfg_wdata[0];
                    CFG_RANGE_FROM:      keep_from = cfg_wdata;
                    CFG_RANGE_LENGTH:    keep_len = cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        results_owed = owed_results.size();
    end

endmodule

[tb/fasta_record_parser_tb.sv]
// Testbench top for the FASTA record parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module fasta_record_parser_tb;
    import fsp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 280;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_wdata = 32'd0;

    int mismatch_count;
    int results_owed;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_go = 0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int words_sent = 0;
    bit amb_now = 1'b1;

    always #4 aclk = ~aclk;

    fasta_record_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fasta_record_parser_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if ((hold_go != 0) && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fasta_record_parser_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_word(txt[i], 1'b0);
        end
    endtask

    task automatic drain_and_pause();
        s_tvalid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input fsp_cfg_index_t idx, input logic [31:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [7:0] pick_base(input bit amb_ok);
        string nt;
        string amb;
        nt = "ACGTNXacgtnx";
        amb = "BDHKMRSVWYbdhkmrsvwy";
        if (amb_ok && ($urandom_range(3) == 0)) begin
            return amb[$urandom_range(amb.len() - 1)];
        end
        return nt[$urandom_range(nt.len() - 1)];
    endfunction

    // Bytes skipped inside a sequence, line feed aside.
    function automatic logic [7:0] pick_filler();
        case ($urandom_range(4))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_CR;
            3: return CHAR_FF;
            default: return CHAR_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    task automatic send_header(input int len);
        logic [7:0] b;
        send_word(CHAR_GT, 1'b0);
        repeat (len) begin
            b = 8'($urandom_range(255));
            while (b == CHAR_LF) b = 8'($urandom_range(255));
            send_word(b, 1'b0);
        end
        send_word(CHAR_LF, 1'b0);
    endtask

    task automatic send_bases(input int count);
        repeat (count) begin
            if ($urandom_range(7) == 0) begin
                send_word(pick_filler(), 1'b0);
            end else begin
                send_word(pick_base(amb_now), 1'b0);
            end
        end
    endtask

    task automatic send_record();
        send_header($urandom_range(10));
        if ($urandom_range(7) == 0) begin
            // Layout right after the header keeps the next '>' at a line start.
            send_word(CHAR_SPACE, 1'b0);
            send_word(CHAR_LF, 1'b0);
        end
        repeat ($urandom_range(3)) begin
            send_bases($urandom_range(15));
            send_word(CHAR_LF, 1'b0);
        end
    endtask

    task automatic maybe_reconfigure();
        if ($urandom_range(5) == 0) begin
            drain_and_pause();
            amb_now = 1'($urandom_range(1));
            write_reg(CFG_ALLOW_AMBIGUOUS, {31'd0, amb_now});
            case ($urandom_range(2))
                0: write_reg(CFG_RANGE_FROM, 32'd0);
                1: write_reg(CFG_RANGE_FROM, 32'hFFFF_FFFF);
                default: write_reg(CFG_RANGE_FROM, $urandom);
            endcase
        end
    endtask

    // Bad characters, end of file and a range all stop the parser until reset,
    // so each run closes with one of them, chosen at random.
    task automatic send_terminal();
        logic [7:0] b;
        string bad_set;
        bad_set = "@Z!>%eEjJqQuU";
        case ($urandom_range(5))
            0: begin
                send_bases(1 + $urandom_range(6));
                send_word(8'($urandom_range(255)), 1'b1);
            end
            1: begin
                send_word(CHAR_GT, 1'b0);
                send_text("hdr");
                send_word(8'($urandom_range(255)), 1'b1);
            end
            2: begin
                send_header($urandom_range(4));
                send_word(8'($urandom_range(255)), 1'b1);
            end
            3: begin
                send_word(pick_base(1'b0), 1'b0);
                if ($urandom_range(1) == 0) begin
                    b = bad_set[$urandom_range(bad_set.len() - 1)];
                end else begin
                    b = 8'($urandom_range(8'h80, 8'hFF));
                end
                send_word(b, 1'b0);
            end
            4: begin
                drain_and_pause();
                amb_now = 1'b0;
                write_reg(CFG_ALLOW_AMBIGUOUS, 32'd0);
                send_word(pick_base(1'b0), 1'b0);
                send_text("k");
            end
            default: begin
                send_header($urandom_range(4));
                drain_and_pause();
                case ($urandom_range(3))
                    0: begin
                        write_reg(CFG_RANGE_FROM, 1 + $urandom_range(7));
                        write_reg(CFG_RANGE_LENGTH, 1 + $urandom_range(7));
                    end
                    1: begin
                        write_reg(CFG_RANGE_FROM, 32'd0);
                        write_reg(CFG_RANGE_LENGTH, 1 + $urandom_range(4));
                    end
                    2: begin
                        write_reg(CFG_RANGE_FROM, 32'hFFFF_FFFF);
                        write_reg(CFG_RANGE_LENGTH, 32'd1);
                    end
                    default: begin
                        write_reg(CFG_RANGE_FROM, 1 + $urandom_range(2));
                        write_reg(CFG_RANGE_LENGTH, 32'hFFFF_FFFF);
                    end
                endcase
                send_bases($urandom_range(20));
                if ($urandom_range(1) == 0) begin
                    send_word(CHAR_LF, 1'b0);
                    send_word(CHAR_GT, 1'b0);
                end else begin
                    send_word(8'($urandom_range(255)), 1'b1);
                end
            end
        endcase
        // Everything after the stop is ignored by the parser.
        repeat (20) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_reg(CFG_ALLOW_AMBIGUOUS, 32'd1);
        write_reg(CFG_RANGE_FROM, 32'hFFFF_FFFF);
        write_reg(CFG_RANGE_LENGTH, 32'd0);

        // Leading layout is skipped, then a record without a header line.
        send_word(CHAR_SPACE, 1'b0);
        send_word(CHAR_TAB, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_FF, 1'b0);
        send_text("aCgTnX");
        send_text("9y0W");
        send_word(CHAR_LF, 1'b0);
        // Header with the extreme byte values.
        send_word(CHAR_GT, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(CHAR_GT, 1'b0);
        send_word(CHAR_LF, 1'b0);
        // Layout after the header, then '>' closes an empty record.
        send_word(CHAR_SPACE, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_word(CHAR_GT, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_text("Gt");
        send_word(CHAR_LF, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == 0) begin
                hold_go = 1;
            end
            while (words_sent < 30 + ITEMS_PER_PHASE * (ph + 1)) begin
                send_record();
                maybe_reconfigure();
            end
        end

        send_terminal();

        s_tvalid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("fasta_record_parser_tb: PASS");
        end else begin
            $display("fasta_record_parser_tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/fsp_pkg.sv
rtl/fsp_core.sv
rtl/fsp_out_fifo.sv
rtl/fasta_record_parser.sv
tb/fasta_record_parser_checker.sv
tb/fasta_record_parser_tb.sv
